[src/semaphore_wait_queue_table_defines.svh]
// Assertion macros for the semaphore wait-queue table.
// No dependencies; included by the top level.
`ifndef SEMAPHORE_WAIT_QUEUE_TABLE_DEFINES_SVH
`define SEMAPHORE_WAIT_QUEUE_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SWQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SWQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWQ_ASSERT(lbl, clk, rst, prop, msg)
`define SWQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[src/swq_pkg.sv]
// Shared types and constants of the semaphore wait-queue table.
// No dependencies.
package swq_pkg;
   localparam int MAX_PROCS = 20;
   localparam int ID_W = 5;
   localparam int ADDR_W = 32;
   localparam logic [ID_W-1:0] NP_ID = ID_W'(MAX_PROCS);

   typedef enum logic [1:0] {
      CMD_BLOCK  = 2'd0,
      CMD_POP    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_PEEK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_BLOCKED   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_MATCH = 2'd1,
      S_LOAD  = 2'd2,
      S_EXEC  = 2'd3
   } state_type;

   typedef struct packed {
      logic take_req;
      logic match;
      logic load;
      logic exec;
   } ctl_type;
endpackage

[src/swq_ctrl.sv]
// Sequencer of the semaphore wait-queue table: match, load, execute.
// Uses swq_pkg.
module swq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output swq_pkg::ctl_type ctl
);
   swq_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         swq_pkg::S_IDLE: begin
            if (req_valid) begin
               ctl.take_req = 1'b1;
               state_in = swq_pkg::S_MATCH;
            end
         end
         swq_pkg::S_MATCH: begin
            ctl.match = 1'b1;
            state_in = swq_pkg::S_LOAD;
         end
         swq_pkg::S_LOAD: begin
            ctl.load = 1'b1;
            state_in = swq_pkg::S_EXEC;
         end
         swq_pkg::S_EXEC: begin
            // wait until the output word is free
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl.exec = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = swq_pkg::S_IDLE;
            end
         end
         default: state_in = swq_pkg::S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != swq_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

[src/swq_datapath.sv]
// Descriptor pool, queue links and response word of the wait-queue table.
// Uses swq_pkg; steered by swq_ctrl.
module swq_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  swq_pkg::ctl_type            ctl,
   input  logic [1:0]                  req_cmd,
   input  logic [swq_pkg::ADDR_W-1:0]  req_sem_addr,
   input  logic [swq_pkg::ID_W-1:0]    req_proc_id,
   output logic [1:0]                  rsp_status,
   output logic [swq_pkg::ID_W-1:0]    rsp_result_proc
);
   localparam int NP = swq_pkg::MAX_PROCS;
   localparam int IW = swq_pkg::ID_W;

   logic [swq_pkg::ADDR_W-1:0] desc_key_ff [NP];
   logic [NP-1:0]              desc_active_ff;
   logic [IW-1:0]              queue_first_ff [NP];
   logic [IW-1:0]              queue_last_ff [NP];
   logic [IW-1:0]              link_after_ff [NP];
   logic [IW-1:0]              link_before_ff [NP];
   logic [IW-1:0]              waiting_on_ff [NP];
   logic [NP-1:0]              is_waiting_ff;

   swq_pkg::cmd_type           cmd_ff;
   logic [swq_pkg::ADDR_W-1:0] addr_ff;
   logic [IW-1:0]              pid_ff;

   logic          hit_ff, hit_in, free_ok_ff, free_ok_in;
   logic [IW-1:0] hit_d_ff, hit_d_in, free_d_ff, free_d_in;

   logic          ok_ff, ok_in, new_ff, new_in;
   logic [IW-1:0] d_ff, d_in, tp_ff, tp_in;
   swq_pkg::status_type st_ff, st_in;

   logic [1:0]    rsp_status_ff;
   logic [IW-1:0] rsp_proc_ff;

   logic          pid_ok;
   logic [IW-1:0] nx, pv, tl;
   logic          head, tail;

   // key match and lowest free descriptor
   always_comb begin
      hit_in = 1'b0;
      hit_d_in = '0;
      free_ok_in = 1'b0;
      free_d_in = '0;
      for (int i = NP - 1; i >= 0; i--) begin
         if (desc_active_ff[i] && desc_key_ff[i] == addr_ff) begin
            hit_in = 1'b1;
            hit_d_in = IW'(i);
         end
         if (!desc_active_ff[i]) begin
            free_ok_in = 1'b1;
            free_d_in = IW'(i);
         end
      end
   end

   assign pid_ok = pid_ff < swq_pkg::NP_ID;

   // choose descriptor and target process
   always_comb begin
      ok_in = 1'b0;
      new_in = 1'b0;
      d_in = hit_d_ff;
      tp_in = pid_ff;
      st_in = swq_pkg::ST_NOT_FOUND;
      unique case (cmd_ff)
         swq_pkg::CMD_BLOCK: begin
            priority if (!pid_ok) begin
               st_in = swq_pkg::ST_NOT_FOUND;
            end else if (is_waiting_ff[pid_ff]) begin
               st_in = swq_pkg::ST_BLOCKED;
            end else if (hit_ff) begin
               ok_in = 1'b1;
            end else if (free_ok_ff) begin
               ok_in = 1'b1;
               new_in = 1'b1;
               d_in = free_d_ff;
            end else begin
               st_in = swq_pkg::ST_FULL;
            end
         end
         swq_pkg::CMD_POP: begin
            if (hit_ff) begin
               tp_in = queue_first_ff[hit_d_ff];
               ok_in = tp_in < swq_pkg::NP_ID;
            end
         end
         swq_pkg::CMD_REMOVE: begin
            if (pid_ok && is_waiting_ff[pid_ff]) begin
               d_in = waiting_on_ff[pid_ff];
               ok_in = (d_in < swq_pkg::NP_ID) && desc_active_ff[d_in];
            end
         end
         swq_pkg::CMD_PEEK: begin
            if (hit_ff) begin
               ok_in = 1'b1;
               tp_in = queue_first_ff[hit_d_ff];
            end
         end
         default: ok_in = 1'b0;
      endcase
   end

   // neighbors of the target process, valid in the execute cycle
   always_comb begin
      nx = link_after_ff[tp_ff];
      pv = link_before_ff[tp_ff];
      tl = queue_last_ff[d_ff];
      head = queue_first_ff[d_ff] == tp_ff;
      tail = tl == tp_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.take_req) begin
         cmd_ff  <= swq_pkg::cmd_type'(req_cmd);
         addr_ff <= req_sem_addr;
         pid_ff  <= req_proc_id;
      end
      if (ctl.match) begin
         hit_ff     <= hit_in;
         hit_d_ff   <= hit_d_in;
         free_ok_ff <= free_ok_in;
         free_d_ff  <= free_d_in;
      end
      if (ctl.load) begin
         ok_ff  <= ok_in;
         new_ff <= new_in;
         d_ff   <= d_in;
         tp_ff  <= tp_in;
         st_ff  <= st_in;
      end
      if (ctl.exec) begin
         if (ok_ff) begin
            rsp_status_ff <= swq_pkg::ST_OK;
            rsp_proc_ff   <= tp_ff;
         end else begin
            rsp_status_ff <= st_ff;
            rsp_proc_ff   <= '0;
         end
         if (ok_ff && cmd_ff == swq_pkg::CMD_BLOCK) begin
            if (new_ff) begin
               desc_key_ff[d_ff]    <= addr_ff;
               queue_first_ff[d_ff] <= tp_ff;
            end else begin
               if (tl < swq_pkg::NP_ID) link_after_ff[tl] <= tp_ff;
               link_before_ff[tp_ff] <= tl;
            end
            queue_last_ff[d_ff]  <= tp_ff;
            link_after_ff[tp_ff] <= tp_ff;
            waiting_on_ff[tp_ff] <= d_ff;
         end
         if (ok_ff && (cmd_ff == swq_pkg::CMD_POP || cmd_ff == swq_pkg::CMD_REMOVE)) begin
            if (!(head && tail)) begin
               if (head) queue_first_ff[d_ff] <= nx;
               else if (pv < swq_pkg::NP_ID) link_after_ff[pv] <= nx;
               if (tail) queue_last_ff[d_ff] <= pv;
               else if (nx < swq_pkg::NP_ID) link_before_ff[nx] <= pv;
            end
         end
      end
   end

   // occupancy flags
   always_ff @(posedge clock) begin
      if (reset) begin
         desc_active_ff <= '0;
         is_waiting_ff  <= '0;
      end else if (ctl.exec && ok_ff) begin
         if (cmd_ff == swq_pkg::CMD_BLOCK) begin
            desc_active_ff[d_ff] <= 1'b1;
            is_waiting_ff[tp_ff] <= 1'b1;
         end else if (cmd_ff == swq_pkg::CMD_POP || cmd_ff == swq_pkg::CMD_REMOVE) begin
            if (head && tail) desc_active_ff[d_ff] <= 1'b0;
            is_waiting_ff[tp_ff] <= 1'b0;
         end
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_result_proc = rsp_proc_ff;
endmodule

[src/semaphore_wait_queue_table.sv]
// Top level of the semaphore wait-queue table (active semaphore list).
// Uses swq_pkg, swq_ctrl, swq_datapath and the assertion macro header.
//
//  channel | ports                                    | direction
//  req     | req_valid req_stall req_cmd req_sem_addr  | in
//          | req_proc_id                              |
//  rsp     | rsp_valid rsp_stall rsp_status           | out
//          | rsp_result_proc                          |
//
// Each command passes through accept, key match over all descriptors,
// load of descriptor and target process, then the pointer update.
// The next word is taken right after the update, even while the response
// word still waits. Reset clears the active and waiting flags at once.
// A stalled response holds the update stage until the output word frees up.
`include "semaphore_wait_queue_table_defines.svh"
module semaphore_wait_queue_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_cmd,
   input  logic [swq_pkg::ADDR_W-1:0]  req_sem_addr,
   input  logic [swq_pkg::ID_W-1:0]    req_proc_id,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [swq_pkg::ID_W-1:0]    rsp_result_proc
);
   swq_pkg::ctl_type ctl;

   // sequencer: one command in flight
   swq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   // tables, queue links and response word
   swq_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .req_cmd         (req_cmd),
      .req_sem_addr    (req_sem_addr),
      .req_proc_id     (req_proc_id),
      .rsp_status      (rsp_status),
      .rsp_result_proc (rsp_result_proc)
   );

   // a failed command never names a process
   `SWQ_ASSERT(a_fail_zero, clock, reset, (rsp_valid && rsp_status != swq_pkg::ST_OK) |-> (rsp_result_proc == '0), "failed response carries a process")
   // once a word is taken the input stays stalled while it is worked on
   `SWQ_ASSERT(a_busy_after_take, clock, reset, (req_valid && !req_stall) |=> req_stall, "input not stalled during work")
endmodule

[bench/tb_semaphore_wait_queue_table.sv]
// Testbench for the semaphore wait-queue table: random and directed commands
// checked against a behavioral table model. Depends on swq_pkg and the top level.
`timescale 1ns / 1ps
module tb_semaphore_wait_queue_table;

   typedef struct packed {
      swq_pkg::cmd_type                cmd;
      logic [swq_pkg::ADDR_W-1:0]      addr;
      logic [swq_pkg::ID_W-1:0]        pid;
   } cmd_word_type;

   typedef struct packed {
      swq_pkg::status_type             status;
      logic [swq_pkg::ID_W-1:0]        proc;
   } rsp_word_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_cmd = '0;
   logic [swq_pkg::ADDR_W-1:0] req_sem_addr = '0;
   logic [swq_pkg::ID_W-1:0] req_proc_id = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0] rsp_status;
   logic [swq_pkg::ID_W-1:0] rsp_result_proc;

   semaphore_wait_queue_table uut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Shadow of the descriptor table.
   logic [swq_pkg::ADDR_W-1:0] sh_key[swq_pkg::MAX_PROCS];
   bit                sh_active[swq_pkg::MAX_PROCS];
   int                sh_first[swq_pkg::MAX_PROCS], sh_last[swq_pkg::MAX_PROCS];
   int                sh_next[swq_pkg::MAX_PROCS], sh_prev[swq_pkg::MAX_PROCS];
   int                sh_on[swq_pkg::MAX_PROCS];
   bit                sh_waiting[swq_pkg::MAX_PROCS];

   cmd_word_type pending_cmds[$];
   rsp_word_type expected_rsps[$];
   int   fail_count = 0;
   int   accepted = 0;
   bit   stim_done = 0;
   logic [swq_pkg::ADDR_W-1:0] addr_pool[8];

   function automatic int lookup_desc(logic [swq_pkg::ADDR_W-1:0] key);
      for (int d = 0; d < swq_pkg::MAX_PROCS; d++)
         if (sh_active[d] && sh_key[d] == key) return d;
      return swq_pkg::MAX_PROCS;
   endfunction

   function automatic void unlink_waiter(int d, int p);
      int nx, pv;
      bit hd, tl;
      nx = sh_next[p];
      pv = sh_prev[p];
      hd = sh_first[d] == p;
      tl = sh_last[d] == p;
      if (hd && tl) begin
         sh_active[d] = 0;
      end else begin
         if (hd) sh_first[d] = nx;
         else if (pv < swq_pkg::MAX_PROCS) sh_next[pv] = nx;
         if (tl) sh_last[d] = pv;
         else if (nx < swq_pkg::MAX_PROCS) sh_prev[nx] = pv;
      end
      sh_waiting[p] = 0;
   endfunction

   // Applies one command to the shadow table, returns the response word.
   function automatic rsp_word_type apply_semaphore_cmd(cmd_word_type w);
      rsp_word_type r;
      int d, p, t, f;
      r.status = swq_pkg::ST_NOT_FOUND;
      r.proc = '0;
      p = w.pid;
      case (w.cmd)
         swq_pkg::CMD_BLOCK: begin
            if (p >= swq_pkg::MAX_PROCS) return r;
            if (sh_waiting[p]) begin
               r.status = swq_pkg::ST_BLOCKED;
               return r;
            end
            d = lookup_desc(w.addr);
            if (d == swq_pkg::MAX_PROCS) begin
               for (d = 0; d < swq_pkg::MAX_PROCS; d++)
                  if (!sh_active[d]) break;
               if (d == swq_pkg::MAX_PROCS) begin
                  r.status = swq_pkg::ST_FULL;
                  return r;
               end
               sh_active[d] = 1;
               sh_key[d] = w.addr;
               sh_first[d] = p;
            end else begin
               t = sh_last[d];
               if (t < swq_pkg::MAX_PROCS) sh_next[t] = p;
               sh_prev[p] = t;
            end
            sh_last[d] = p;
            sh_next[p] = p;
            sh_on[p] = d;
            sh_waiting[p] = 1;
            r.status = swq_pkg::ST_OK;
            r.proc = p[swq_pkg::ID_W-1:0];
         end
         swq_pkg::CMD_POP: begin
            d = lookup_desc(w.addr);
            if (d == swq_pkg::MAX_PROCS || sh_first[d] >= swq_pkg::MAX_PROCS) return r;
            f = sh_first[d];
            r.proc = f[swq_pkg::ID_W-1:0];
            unlink_waiter(d, f);
            r.status = swq_pkg::ST_OK;
         end
         swq_pkg::CMD_REMOVE: begin
            if (p >= swq_pkg::MAX_PROCS || !sh_waiting[p]) return r;
            d = sh_on[p];
            if (!sh_active[d]) return r;
            unlink_waiter(d, p);
            r.status = swq_pkg::ST_OK;
            r.proc = p[swq_pkg::ID_W-1:0];
         end
         default: begin
            d = lookup_desc(w.addr);
            if (d == swq_pkg::MAX_PROCS) return r;
            f = sh_first[d];
            r.status = swq_pkg::ST_OK;
            r.proc = f[swq_pkg::ID_W-1:0];
         end
      endcase
      return r;
   endfunction

   function automatic cmd_word_type mk(swq_pkg::cmd_type c,
                                       logic [swq_pkg::ADDR_W-1:0] a, int p);
      cmd_word_type w;
      w.cmd = c;
      w.addr = a;
      w.pid = p[swq_pkg::ID_W-1:0];
      return w;
   endfunction

   // Stimulus: directed corners, then mostly pool addresses so queues grow deep.
   initial begin
      cmd_word_type w;
      int sel;
      int pr;
      for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      pending_cmds.push_back(mk(swq_pkg::CMD_POP, 32'h0, 0));         // pop on empty table
      pending_cmds.push_back(mk(swq_pkg::CMD_PEEK, 32'hFFFF_FFFF, 0)); // peek on empty table
      pending_cmds.push_back(mk(swq_pkg::CMD_REMOVE, 32'h0, 3));      // remove of idle process
      pending_cmds.push_back(mk(swq_pkg::CMD_BLOCK, 32'h0, 20));      // id out of range
      pending_cmds.push_back(mk(swq_pkg::CMD_REMOVE, 32'h0, 31));     // id out of range
      pending_cmds.push_back(mk(swq_pkg::CMD_BLOCK, 32'h0, 0));
      pending_cmds.push_back(mk(swq_pkg::CMD_BLOCK, 32'hFFFF_FFFF, 19));
      pending_cmds.push_back(mk(swq_pkg::CMD_BLOCK, 32'h0, 5));
      pending_cmds.push_back(mk(swq_pkg::CMD_BLOCK, 32'h1234, 5));    // already blocked
      pending_cmds.push_back(mk(swq_pkg::CMD_PEEK, 32'h0, 0));
      pending_cmds.push_back(mk(swq_pkg::CMD_REMOVE, 32'h0, 0));      // remove the head
      pending_cmds.push_back(mk(swq_pkg::CMD_POP, 32'h0, 0));         // empties, frees
      pending_cmds.push_back(mk(swq_pkg::CMD_POP, 32'hFFFF_FFFF, 0));
      // fill every descriptor, then one more new address from a waiting process is blocked
      for (int i = 0; i < 20; i++)
         pending_cmds.push_back(mk(swq_pkg::CMD_BLOCK, 32'h100 + i, i));
      pending_cmds.push_back(mk(swq_pkg::CMD_BLOCK, 32'h999, 7));
      for (int i = 19; i >= 0; i--)
         pending_cmds.push_back(mk(swq_pkg::CMD_REMOVE, 32'h0, i));
      for (int n = 0; n < 1500; n++) begin
         sel = $urandom_range(0, 9);
         w.cmd = swq_pkg::cmd_type'($urandom_range(0, 3));
         if (sel < 2) w.cmd = swq_pkg::CMD_BLOCK;
         w.addr = (sel == 9) ? $urandom : addr_pool[$urandom_range(0, 7)];
         pr = (sel == 8) ? $urandom_range(0, 31) : $urandom_range(0, 19);
         w.pid = pr[swq_pkg::ID_W-1:0];
         // occasional rotation of a pool address to bring in new keys
         if ($urandom_range(0, 99) == 0) addr_pool[$urandom_range(2, 7)] = $urandom;
         pending_cmds.push_back(w);
      end
      stim_done = 1;
   end

   // Driver: random gap per word, holds payload while stalled.
   int gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         gap <= 0;
      end else if (req_valid && !req_stall) begin
         expected_rsps.push_back(apply_semaphore_cmd(pending_cmds.pop_front()));
         accepted <= accepted + 1;
         req_valid <= 0;
         gap <= (accepted % 300 < 60) ? 0 : $urandom_range(0, 14);
      end else if (!req_valid) begin
         if (gap > 0) gap <= gap - 1;
         else if (pending_cmds.size() > 0) begin
            req_valid <= 1;
            req_cmd <= pending_cmds[0].cmd;
            req_sem_addr <= pending_cmds[0].addr;
            req_proc_id <= pending_cmds[0].pid;
         end
      end
   end

   // Monitor: random stall per word, plus one long hold-off to back up the block.
   int hold = 0;
   int long_hold = 0;
   bit long_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response status=%0d proc=%0d",
                        $time, rsp_status, rsp_result_proc);
               fail_count++;
            end else begin
               rsp_word_type e;
               e = expected_rsps.pop_front();
               if (rsp_status !== e.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.status,
                           rsp_status);
                  fail_count++;
               end
               if (rsp_result_proc !== e.proc) begin
                  $display("%0t: result_proc expected %0d actual %0d", $time, e.proc,
                           rsp_result_proc);
                  fail_count++;
               end
            end
         end
         if (!long_done && accepted >= 100) begin
            long_done <= 1;
            long_hold <= 300;
            rsp_stall <= 1;
         end else if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            rsp_stall <= (long_hold > 1);
         end else if (rsp_valid && !rsp_stall) begin
            hold = (accepted % 300 < 60) ? 0 : $urandom_range(0, 14);
            rsp_stall <= hold > 0;
         end else if (rsp_stall && hold > 0) begin
            hold--;
            rsp_stall <= hold > 0;
         end
      end
   end

   // Reset, end of run and timeout.
   initial begin
      int cyc;
      repeat (5) @(posedge clock);
      reset <= 0;
      cyc = 0;
      while (!(stim_done && pending_cmds.size() == 0 && !req_valid
               && expected_rsps.size() == 0) && cyc < 200000) begin
         @(posedge clock);
         cyc++;
      end
      if (cyc >= 200000) begin
         $display("tb_semaphore_wait_queue_table NOT OK");
      end else begin
         repeat (20) @(posedge clock);
         if (fail_count == 0) begin
            $display("tb_semaphore_wait_queue_table OK");
         end else begin
            $display("tb_semaphore_wait_queue_table NOT OK");
         end
      end
      $finish;
   end
endmodule
